FILE: sv/lmsce_pkg.sv
package lmsce_pkg;

    // display geometry
    localparam int NUM_DEVICES = 4;
    localparam int ROWS        = 8;
    localparam int DEPTH       = NUM_DEVICES * ROWS;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int INIT_N      = (NUM_DEVICES < 4) ? NUM_DEVICES : 4;

    // command codes
    typedef enum logic [3:0] {
        OP_SET_LED   = 4'd0,
        OP_SET_ROW   = 4'd1,
        OP_SET_COL   = 4'd2,
        OP_GET_LED   = 4'd3,
        OP_GET_ROW   = 4'd4,
        OP_GET_COL   = 4'd5,
        OP_CLEAR     = 4'd6,
        OP_SHUTDOWN  = 4'd7,
        OP_INTENSITY = 4'd8,
        OP_SCANLIMIT = 4'd9,
        OP_INIT      = 4'd10
    } op_t;

    // display chip register addresses
    localparam logic [3:0] ADDR_DIGIT_BASE = 4'd1;
    localparam logic [3:0] ADDR_DECODE     = 4'd9;
    localparam logic [3:0] ADDR_INTENSITY  = 4'd10;
    localparam logic [3:0] ADDR_SCAN       = 4'd11;
    localparam logic [3:0] ADDR_SHUTDOWN   = 4'd12;
    localparam logic [3:0] ADDR_NONE       = 4'd0;

    // result kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_OP
    } state_t;

    // one command item
    typedef struct packed {
        logic [3:0] op;
        logic [1:0] device;
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] value;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic       kind;
        logic [1:0] frame_device;
        logic [3:0] chip_addr;
        logic [7:0] frame_data;
        logic [7:0] read_value;
        logic       last;
    } res_t;

    // shadow memory access from the sequencer
    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage

FILE: sv/led_matrix_shadow_command_engine.sv
// an accepted item passes the S_RD state (shadow read) and the S_OP state before its first
// result enters the output register; a column get answers once, after all eight row reads
// each shadow row step is a read in S_RD, then modify and write in S_OP
// column set, column get and clear step over eight rows; new items are taken only in S_IDLE
// init steps over each device, up to four; output stalls hold the sequencer
// reset: asynchronous, active low; the shadow reads as all zero through per-row valid bits
module led_matrix_shadow_command_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // op[3:0], device[5:4], row[8:6], col[11:9], value[19:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // frame_device[1:0], chip_addr[5:2], frame_data[13:6],
                                        // read_value[21:14]
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);

    lmsce_pkg::cmd_t     cmd;
    lmsce_pkg::res_t     res;
    lmsce_pkg::res_t     out_res;
    lmsce_pkg::mem_req_t mem_req;
    logic [7:0]          mem_rdata;
    logic                res_valid;
    logic                res_ready;

    // unpack the command item
    assign cmd.op     = s_axis_tdata[3:0];
    assign cmd.device = s_axis_tdata[5:4];
    assign cmd.row    = s_axis_tdata[8:6];
    assign cmd.col    = s_axis_tdata[11:9];
    assign cmd.value  = s_axis_tdata[19:12];

    lmsce_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // shadow rows, one byte per device row
    lmsce_ram #(
        .WIDTH (8),
        .DEPTH (lmsce_pkg::DEPTH)
    ) u_shadow (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    lmsce_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // pack the result item
    assign m_axis_tdata = {2'b00, out_res.read_value, out_res.frame_data,
                           out_res.chip_addr, out_res.frame_device};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

    // every shadow write goes out as a frame in the same cycle
    a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (res_valid && res_ready && res.kind == lmsce_pkg::KIND_FRAME))
        else $error("shadow write without a display frame");

    // read and write of the shadow never share a cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.re && mem_req.we))
        else $error("shadow read and write in the same cycle");

    // the last result of a command frees the input
    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && res.last) |=> s_axis_tready)
        else $error("input not ready after final result");

    // the input is closed while a result is pending
    a_busy_when_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

endmodule

FILE: sv/lmsce_ram.sv
module lmsce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/lmsce_seq.sv
module lmsce_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  lmsce_pkg::cmd_t       cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output lmsce_pkg::res_t       res,
    output lmsce_pkg::mem_req_t   mem_req,
    input  logic [7:0]            mem_rdata
);

    lmsce_pkg::state_t               state_reg, state_next;
    logic [3:0]                      op_reg;
    logic [1:0]                      dev_reg;
    logic [2:0]                      row_reg;
    logic [2:0]                      col_reg;
    logic [7:0]                      val_reg;
    logic                            present_reg;
    logic [2:0]                      step_reg;
    logic [6:0]                      acc_reg;
    logic                            rdv_reg;
    logic [lmsce_pkg::DEPTH-1:0]     valid_reg;

    logic                            start;
    logic                            cmd_present;
    logic                            cmd_known;
    logic                            cmd_is_get;
    logic                            loop8;
    logic [2:0]                      row_idx;
    logic [lmsce_pkg::ADDR_W-1:0]    addr;
    logic [7:0]                      cur;
    logic [7:0]                      mask;
    logic                            bit_on;
    logic [7:0]                      new_row;
    logic                            emit;
    logic                            wr;
    logic                            last_step;
    logic                            fire;

    // command decode at the input
    assign cmd_present = int'(cmd.device) < lmsce_pkg::NUM_DEVICES;
    assign cmd_known   = cmd.op <= lmsce_pkg::OP_INIT;
    assign cmd_is_get  = cmd.op inside {lmsce_pkg::OP_GET_LED, lmsce_pkg::OP_GET_ROW,
                                        lmsce_pkg::OP_GET_COL};
    assign start       = cmd_valid && cmd_ready && cmd_known
                         && (cmd_present || cmd_is_get || cmd.op == lmsce_pkg::OP_INIT);

    // row addressed in this step
    assign loop8   = op_reg inside {lmsce_pkg::OP_SET_COL, lmsce_pkg::OP_GET_COL,
                                    lmsce_pkg::OP_CLEAR};
    assign row_idx = loop8 ? step_reg : row_reg;
    assign addr    = present_reg ? lmsce_pkg::ADDR_W'({dev_reg, row_idx}) : '0;

    // shadow row, never written entries read as zero
    assign cur  = rdv_reg ? mem_rdata : 8'h00;
    assign mask = 8'h01 << col_reg;

    // per command step: new row, result and write decision
    always_comb
    begin
        bit_on    = 1'b0;
        new_row   = cur;
        emit      = 1'b1;
        wr        = 1'b0;
        last_step = 1'b1;
        res       = '0;
        res.frame_device = dev_reg;
        case (op_reg)
            lmsce_pkg::OP_SET_LED:
            begin
                bit_on        = val_reg != 8'h00;
                new_row       = bit_on ? (cur | mask) : (cur & ~mask);
                wr            = 1'b1;
                res.chip_addr = lmsce_pkg::ADDR_DIGIT_BASE + {1'b0, row_idx};
                res.frame_data = new_row;
            end
            lmsce_pkg::OP_SET_ROW:
            begin
                new_row       = val_reg;
                wr            = 1'b1;
                res.chip_addr = lmsce_pkg::ADDR_DIGIT_BASE + {1'b0, row_idx};
                res.frame_data = new_row;
            end
            lmsce_pkg::OP_SET_COL:
            begin
                bit_on        = val_reg[step_reg];
                new_row       = bit_on ? (cur | mask) : (cur & ~mask);
                wr            = 1'b1;
                last_step     = step_reg == 3'd7;
                res.chip_addr = lmsce_pkg::ADDR_DIGIT_BASE + {1'b0, row_idx};
                res.frame_data = new_row;
            end
            lmsce_pkg::OP_GET_LED:
            begin
                res.kind       = lmsce_pkg::KIND_READ;
                res.read_value = present_reg ? {7'b0, cur[col_reg]} : 8'h00;
            end
            lmsce_pkg::OP_GET_ROW:
            begin
                res.kind       = lmsce_pkg::KIND_READ;
                res.read_value = present_reg ? cur : 8'h00;
            end
            lmsce_pkg::OP_GET_COL:
            begin
                last_step      = step_reg == 3'd7;
                emit           = last_step;
                res.kind       = lmsce_pkg::KIND_READ;
                res.read_value = present_reg ? {cur[col_reg], acc_reg} : 8'h00;
            end
            lmsce_pkg::OP_CLEAR:
            begin
                new_row       = 8'h00;
                wr            = 1'b1;
                last_step     = step_reg == 3'd7;
                res.chip_addr = lmsce_pkg::ADDR_DIGIT_BASE + {1'b0, row_idx};
                res.frame_data = 8'h00;
            end
            lmsce_pkg::OP_SHUTDOWN:
            begin
                res.chip_addr  = lmsce_pkg::ADDR_SHUTDOWN;
                res.frame_data = {7'b0, val_reg == 8'h00};
            end
            lmsce_pkg::OP_INTENSITY:
            begin
                res.chip_addr  = lmsce_pkg::ADDR_INTENSITY;
                res.frame_data = val_reg;
            end
            lmsce_pkg::OP_SCANLIMIT:
            begin
                res.chip_addr  = lmsce_pkg::ADDR_SCAN;
                res.frame_data = val_reg;
            end
            lmsce_pkg::OP_INIT:
            begin
                last_step        = step_reg == 3'(lmsce_pkg::INIT_N - 1);
                res.frame_device = step_reg[1:0];
                res.chip_addr    = lmsce_pkg::ADDR_DECODE;
                res.frame_data   = 8'h00;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        res.last = last_step;
    end

    // a step completes once its result is taken, or at once when it emits none
    assign fire = (state_reg == lmsce_pkg::S_OP) && (!emit || res_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmsce_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = lmsce_pkg::S_RD;
                end
            end
            lmsce_pkg::S_RD:
            begin
                state_next = lmsce_pkg::S_OP;
            end
            lmsce_pkg::S_OP:
            begin
                if (fire)
                begin
                    state_next = last_step ? lmsce_pkg::S_IDLE : lmsce_pkg::S_RD;
                end
            end
            default:
            begin
                state_next = lmsce_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd_ready     = 1'b0;
        res_valid     = 1'b0;
        mem_req       = '0;
        mem_req.raddr = addr;
        mem_req.waddr = addr;
        mem_req.wdata = new_row;
        case (state_reg)
            lmsce_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            lmsce_pkg::S_RD:
            begin
                mem_req.re = 1'b1;
            end
            lmsce_pkg::S_OP:
            begin
                res_valid  = emit;
                mem_req.we = fire && emit && wr;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmsce_pkg::S_IDLE;
            valid_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_req.we)
            begin
                valid_reg[mem_req.waddr] <= 1'b1;
            end
            if (start)
            begin
                step_reg <= '0;
            end
            else if (fire && !last_step)
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    // command and step data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg      <= cmd.op;
            dev_reg     <= cmd.device;
            row_reg     <= cmd.row;
            col_reg     <= cmd.col;
            val_reg     <= cmd.value;
            present_reg <= cmd_present;
        end
        if (mem_req.re)
        begin
            rdv_reg <= valid_reg[addr];
        end
        if (fire)
        begin
            acc_reg <= {cur[col_reg], acc_reg[6:1]};
        end
    end

endmodule

FILE: sv/lmsce_out.sv
module lmsce_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lmsce_pkg::res_t in_res,
    output logic            out_valid,
    input  logic            out_ready,
    output lmsce_pkg::res_t out_res
);

    logic            full_reg;
    lmsce_pkg::res_t data_reg;

    // slot frees as the held item leaves
    assign in_ready  = !full_reg || out_ready;
    assign out_valid = full_reg;
    assign out_res   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_res;
        end
    end

endmodule
